@@ rtl/lru_write_back_line_cache_assert.svh @@
// Assertion macros shared by the checker of the line cache.
// Needs clk and rst_n in the scope of use.
`ifndef LRU_WRITE_BACK_LINE_CACHE_ASSERT_SVH
`define LRU_WRITE_BACK_LINE_CACHE_ASSERT_SVH
`define LWB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LWB_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

@@ rtl/lwbc_pkg.sv @@
// Shared constants and command/status types for the line cache.
// No dependencies.
package lwbc_pkg;
    localparam int LINES = 16;
    localparam int SLOT_W = $clog2(LINES);
    localparam int OFF_W = 2;
    localparam int LINES_PER_SEGMENT = 8;
    localparam int SEG_W = $clog2(LINES_PER_SEGMENT);
    localparam int LINE_W = 18;
    localparam int BLK_W = 20;
    localparam int SADDR_W = 15;
    // result fields packed from kind up, last in the top bit
    localparam int RES_W = 48;
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_FLUSH = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    typedef struct packed {
        logic             load;    // latch a new item
        logic             claim;   // look up / allocate line_reg
        logic             flush_step; // evaluate flush scan slot
        logic             next_line;  // advance segment line
    } cmd_t;

    typedef struct packed {
        logic [1:0]       op;
        logic             seg_done;   // current segment line is the final one
        logic             scan_done;  // flush scan at its final slot
    } status_t;
endpackage

@@ rtl/lwbc_datapath.sv @@
// Tag, dirty, valid and LRU rank storage with the claim and flush scan logic.
// Depends on lwbc_pkg.
module lwbc_datapath
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  lwbc_pkg::cmd_t              cmd,
    output lwbc_pkg::status_t           status,
    input  logic [1:0]                  in_op,
    input  logic [lwbc_pkg::BLK_W-1:0]  in_blk,
    input  logic [lwbc_pkg::SADDR_W-1:0] in_seg,
    output logic                        res_emit,
    output logic [lwbc_pkg::RES_W-1:0]  res_data
);
    localparam int L = lwbc_pkg::LINES;
    localparam int SW = lwbc_pkg::SLOT_W;
    localparam int LW = lwbc_pkg::LINE_W;

    logic [L-1:0]      valid_reg, dirty_reg;
    logic [LW-1:0]     tag_reg [L];
    logic [SW-1:0]     rank_reg [L];
    logic [1:0]        op_reg;
    logic [LW-1:0]     line_reg;
    logic [1:0]        off_reg;
    logic [lwbc_pkg::SEG_W-1:0] seg_cnt_reg;
    logic [SW-1:0]     scan_reg;
    logic              any_reg;

    logic [L-1:0]      match;
    logic              hit;
    logic [SW-1:0]     hit_slot, vic_slot, use_slot;
    logic [L-1:0]      dv;
    logic              last_dirty;

    always_comb
    begin
        hit = 1'b0;
        hit_slot = '0;
        vic_slot = '0;
        for (int k = 0; k < L; k++)
        begin
            match[k] = valid_reg[k] && (tag_reg[k] == line_reg);
            if (match[k])
            begin
                hit = 1'b1;
                hit_slot = SW'(k);
            end
            if (rank_reg[k] == '0)
                vic_slot = SW'(k);
        end
        use_slot = hit ? hit_slot : vic_slot;
        dv = valid_reg & dirty_reg;
        // scan slot is the final dirty one when no dirty slot sits above it
        last_dirty = ((dv >> scan_reg) >> 1) == '0;
    end

    assign status.op = op_reg;
    assign status.seg_done = seg_cnt_reg == lwbc_pkg::SEG_W'(lwbc_pkg::LINES_PER_SEGMENT - 1);
    assign status.scan_done = scan_reg == SW'(L - 1);

    logic wbv;
    assign wbv = !hit && valid_reg[vic_slot] && dirty_reg[vic_slot];

    always_comb
    begin
        res_emit = 1'b0;
        res_data = '0;
        if (cmd.claim)
        begin
            res_emit = 1'b1;
            res_data = {status.op == lwbc_pkg::OP_READ || status.seg_done,
                        (op_reg == lwbc_pkg::OP_READ) ? off_reg : 2'd0,
                        line_reg,
                        wbv ? tag_reg[vic_slot] : LW'(0),
                        wbv, !hit && op_reg == lwbc_pkg::OP_READ, hit,
                        use_slot, op_reg};
        end
        else if (cmd.flush_step)
        begin
            if (dv[scan_reg])
            begin
                res_emit = 1'b1;
                res_data = {last_dirty, 2'd0, tag_reg[scan_reg], tag_reg[scan_reg],
                            1'b1, 1'b0, 1'b1, scan_reg, lwbc_pkg::OP_FLUSH};
            end
            else if (status.scan_done && !any_reg)
            begin
                res_emit = 1'b1;
                res_data = {1'b1, 45'd0, lwbc_pkg::OP_FLUSH};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            dirty_reg <= '0;
            for (int k = 0; k < L; k++)
                rank_reg[k] <= SW'(k);
            op_reg <= '0;
            seg_cnt_reg <= '0;
            scan_reg <= '0;
            any_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                op_reg <= in_op;
                seg_cnt_reg <= '0;
                scan_reg <= '0;
                any_reg <= 1'b0;
            end
            if (cmd.claim)
            begin
                for (int k = 0; k < L; k++)
                    if (rank_reg[k] > rank_reg[use_slot])
                        rank_reg[k] <= rank_reg[k] - 1'b1;
                rank_reg[use_slot] <= SW'(L - 1);
                if (!hit)
                begin
                    valid_reg[use_slot] <= 1'b1;
                    dirty_reg[use_slot] <= op_reg == lwbc_pkg::OP_WRITE;
                end
                else if (op_reg == lwbc_pkg::OP_WRITE)
                    dirty_reg[use_slot] <= 1'b1;
            end
            if (cmd.next_line)
                seg_cnt_reg <= seg_cnt_reg + 1'b1;
            if (cmd.flush_step)
            begin
                if (dv[scan_reg])
                    any_reg <= 1'b1;
                scan_reg <= scan_reg + 1'b1;
            end
        end
    end

    // payload registers without reset
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            line_reg <= (in_op == lwbc_pkg::OP_READ) ? in_blk[lwbc_pkg::BLK_W-1:2]
                        : {in_seg, lwbc_pkg::SEG_W'(0)};
            off_reg <= in_blk[1:0];
        end
        else if (cmd.next_line)
            line_reg <= line_reg + 1'b1;
        if (cmd.claim && !hit)
            tag_reg[use_slot] <= line_reg;
    end
endmodule

@@ rtl/lwbc_ctrl.sv @@
// Sequencer for reads, segment writes and flush scans; owns the output register.
// Depends on lwbc_pkg.
module lwbc_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         in_op,
    output lwbc_pkg::cmd_t     cmd,
    input  lwbc_pkg::status_t  status,
    input  logic               res_emit,
    input  logic [lwbc_pkg::RES_W-1:0] res_data,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [lwbc_pkg::RES_W-1:0] out_data
);
    typedef enum logic [1:0] {S_IDLE, S_CLAIM, S_FLUSH} state_t;
    state_t state_reg, state_next;
    logic   out_valid_reg;
    logic   free;

    // output slot is free when empty or being taken now
    assign free = !out_valid_reg || out_ready;
    assign in_ready = state_reg == S_IDLE;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_op != lwbc_pkg::OP_NONE)
                begin
                    cmd.load = 1'b1;
                    state_next = (in_op == lwbc_pkg::OP_FLUSH) ? S_FLUSH : S_CLAIM;
                end
            end
            S_CLAIM:
            begin
                if (free)
                begin
                    cmd.claim = 1'b1;
                    if (status.op == lwbc_pkg::OP_READ || status.seg_done)
                        state_next = S_IDLE;
                    else
                        cmd.next_line = 1'b1;
                end
            end
            S_FLUSH:
            begin
                if (free)
                begin
                    cmd.flush_step = 1'b1;
                    if (status.scan_done)
                        state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
            out_data <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (res_emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (res_emit)
                out_data <= res_data;
        end
    end
endmodule

@@ rtl/lru_write_back_line_cache.sv @@
// Fully associative write-back line cache controller, 16 slots, true LRU.
// Read: accepted in the idle state, then claimed; segment write: accepted, then each of its 8 lines claimed;
// flush: accepted, then one slot scanned per cycle by the flush sequencer while the output slot is free.
// A result waits in the output register; a stalled output holds the sequencer.
// Asynchronous reset: all slots invalid and clean, slot k holds rank k.
module lru_write_back_line_cache
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // op[1:0], block_address[21:2], segment_address[36:22]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,  // kind[1:0], slot[5:2], hit[6], fill_needed[7],
                                       // writeback_valid[8], writeback_line[26:9],
                                       // line_number[44:27], block_offset[46:45]
    output logic        m_axis_tlast
);
    lwbc_pkg::cmd_t    cmd;
    lwbc_pkg::status_t status;
    logic              res_emit;
    logic [lwbc_pkg::RES_W-1:0] res_data, out_data;

    lwbc_datapath u_dp
    (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .status(status),
        .in_op(s_axis_tdata[1:0]), .in_blk(s_axis_tdata[21:2]),
        .in_seg(s_axis_tdata[36:22]), .res_emit(res_emit), .res_data(res_data)
    );

    lwbc_ctrl u_ctrl
    (
        .clk(clk), .rst_n(rst_n), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .in_op(s_axis_tdata[1:0]), .cmd(cmd), .status(status), .res_emit(res_emit),
        .res_data(res_data), .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_data(out_data)
    );

    assign m_axis_tdata = {1'b0, out_data[46:0]};
    assign m_axis_tlast = out_data[47];
endmodule

@@ rtl/lwbc_checker.sv @@
// Port-level checker for the line cache, bound to the top level.
// Depends on lru_write_back_line_cache_assert.svh and lwbc_pkg.
`include "lru_write_back_line_cache_assert.svh"
module lwbc_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [39:0] s_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic        m_axis_tlast
);
    logic op_ok;
    assign op_ok = s_axis_tdata[1:0] != lwbc_pkg::OP_NONE;

    `LWB_ASSERT(a_busy_after_accept, s_axis_tvalid && s_axis_tready && op_ok |=> !s_axis_tready, "input taken while busy")
    `LWB_ASSERT(a_read_last, m_axis_tvalid && m_axis_tdata[1:0] == 2'd0 |-> m_axis_tlast, "read result without last")
    `LWB_ASSERT(a_fill_on_miss, m_axis_tvalid && m_axis_tdata[7] |-> !m_axis_tdata[6] && m_axis_tdata[1:0] == 2'd0, "fill with hit")
    `LWB_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "output word changed while stalled")
    `LWB_ASSERT_RST(a_reset_idle, !rst_n |-> !m_axis_tvalid, "output valid in reset")
endmodule

bind lru_write_back_line_cache lwbc_checker u_chk
(
    .clk(clk), .rst_n(rst_n), .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
);

@@ sim/testbench.sv @@
// Self-checking testbench for the LRU write-back line cache controller.
// Depends on lwbc_pkg and lru_write_back_line_cache; predicts results in place.
module testbench;
    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  slot;
        logic        hit;
        logic        fill_needed;
        logic        writeback_valid;
        logic [17:0] writeback_line;
        logic [17:0] line_number;
        logic [1:0]  block_offset;
        logic        last;
    } result_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;   // op, block_address, segment_address
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;   // kind, slot, hit, fill_needed, writeback_valid,
                                 // writeback_line, line_number, block_offset
    logic        m_axis_tlast;

    logic [39:0] pending_words[$];
    result_t     expected_results[$];
    int          error_count = 0;
    int          send_idle_pct;
    int          recv_stall_pct;

    // predictor state
    logic        cache_valid[lwbc_pkg::LINES];
    logic [17:0] cache_tag[lwbc_pkg::LINES];
    logic        cache_dirty[lwbc_pkg::LINES];
    logic [3:0]  cache_rank[lwbc_pkg::LINES];

    lru_write_back_line_cache u_top (.*);

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #80_000_000;
        $display("status: fail");
        $finish;
    end

    function automatic void predictor_reset();
        for (int k = 0; k < lwbc_pkg::LINES; k++)
        begin
            cache_valid[k] = 1'b0;
            cache_tag[k] = '0;
            cache_dirty[k] = 1'b0;
            cache_rank[k] = 4'(k);
        end
    endfunction

    function automatic void make_newest(int s);
        logic [3:0] r;
        r = cache_rank[s];
        for (int k = 0; k < lwbc_pkg::LINES; k++)
            if (cache_rank[k] > r)
                cache_rank[k]--;
        cache_rank[s] = 4'(lwbc_pkg::LINES - 1);
    endfunction

    // find or allocate the slot for a line, fill in hit and eviction fields
    function automatic int claim_slot(logic [17:0] line, inout result_t res);
        int s;
        s = -1;
        res.hit = 1'b0;
        res.writeback_valid = 1'b0;
        res.writeback_line = '0;
        for (int k = 0; k < lwbc_pkg::LINES; k++)
            if (s < 0 && cache_valid[k] && cache_tag[k] == line)
                s = k;
        if (s >= 0)
            res.hit = 1'b1;
        else
        begin
            for (int k = 0; k < lwbc_pkg::LINES; k++)
                if (cache_rank[k] == 0)
                    s = k;
            if (cache_valid[s] && cache_dirty[s])
            begin
                res.writeback_valid = 1'b1;
                res.writeback_line = cache_tag[s];
            end
            cache_valid[s] = 1'b1;
            cache_tag[s] = line;
            cache_dirty[s] = 1'b0;
        end
        make_newest(s);
        res.slot = 4'(s);
        res.line_number = line;
        return s;
    endfunction

    function automatic void predict_cache_results(logic [39:0] word);
        logic [1:0]  op;
        logic [19:0] blk;
        logic [14:0] seg;
        logic [17:0] first;
        result_t     res;
        int          s;
        int          last_dirty;
        op = word[1:0];
        blk = word[21:2];
        seg = word[36:22];
        if (op == lwbc_pkg::OP_READ)
        begin
            res = '0;
            res.kind = lwbc_pkg::OP_READ;
            s = claim_slot(blk[19:2], res);
            res.fill_needed = ~res.hit;
            res.block_offset = blk[1:0];
            res.last = 1'b1;
            expected_results.push_back(res);
        end
        else if (op == lwbc_pkg::OP_WRITE)
        begin
            first = 18'({seg, 3'b000});
            for (int j = 0; j < lwbc_pkg::LINES_PER_SEGMENT; j++)
            begin
                res = '0;
                res.kind = lwbc_pkg::OP_WRITE;
                s = claim_slot(first + 18'(j), res);
                cache_dirty[s] = 1'b1;
                res.last = (j == lwbc_pkg::LINES_PER_SEGMENT - 1);
                expected_results.push_back(res);
            end
        end
        else if (op == lwbc_pkg::OP_FLUSH)
        begin
            last_dirty = -1;
            for (int k = 0; k < lwbc_pkg::LINES; k++)
                if (cache_valid[k] && cache_dirty[k])
                    last_dirty = k;
            if (last_dirty < 0)
            begin
                res = '0;
                res.kind = lwbc_pkg::OP_FLUSH;
                res.last = 1'b1;
                expected_results.push_back(res);
            end
            else
                for (int k = 0; k < lwbc_pkg::LINES; k++)
                    if (cache_valid[k] && cache_dirty[k])
                    begin
                        res = '0;
                        res.kind = lwbc_pkg::OP_FLUSH;
                        res.slot = 4'(k);
                        res.hit = 1'b1;
                        res.writeback_valid = 1'b1;
                        res.writeback_line = cache_tag[k];
                        res.line_number = cache_tag[k];
                        res.last = (k == last_dirty);
                        expected_results.push_back(res);
                    end
        end
    endfunction

    function automatic logic [39:0] pack_word(logic [1:0] op, logic [19:0] blk,
                                              logic [14:0] seg);
        return {3'b000, seg, blk, op};
    endfunction

    // driver: hold the word until accepted, then predict on acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                predict_cache_results(s_axis_tdata);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= pending_words.pop_front();
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor
    always @(posedge clk)
    begin
        result_t got;
        result_t exp_res;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.kind = m_axis_tdata[1:0];
            got.slot = m_axis_tdata[5:2];
            got.hit = m_axis_tdata[6];
            got.fill_needed = m_axis_tdata[7];
            got.writeback_valid = m_axis_tdata[8];
            got.writeback_line = m_axis_tdata[26:9];
            got.line_number = m_axis_tdata[44:27];
            got.block_offset = m_axis_tdata[46:45];
            got.last = m_axis_tlast;
            if (expected_results.size() == 0)
            begin
                $error("unexpected result word %h", m_axis_tdata);
                error_count++;
            end
            else
            begin
                exp_res = expected_results.pop_front();
                if (got.kind !== exp_res.kind)
                begin
                    $error("kind: expected %0d, got %0d", exp_res.kind, got.kind);
                    error_count++;
                end
                if (got.slot !== exp_res.slot)
                begin
                    $error("slot: expected %0d, got %0d", exp_res.slot, got.slot);
                    error_count++;
                end
                if (got.hit !== exp_res.hit)
                begin
                    $error("hit: expected %0d, got %0d", exp_res.hit, got.hit);
                    error_count++;
                end
                if (got.fill_needed !== exp_res.fill_needed)
                begin
                    $error("fill_needed: expected %0d, got %0d",
                           exp_res.fill_needed, got.fill_needed);
                    error_count++;
                end
                if (got.writeback_valid !== exp_res.writeback_valid)
                begin
                    $error("writeback_valid: expected %0d, got %0d",
                           exp_res.writeback_valid, got.writeback_valid);
                    error_count++;
                end
                if (got.writeback_line !== exp_res.writeback_line)
                begin
                    $error("writeback_line: expected %0d, got %0d",
                           exp_res.writeback_line, got.writeback_line);
                    error_count++;
                end
                if (got.line_number !== exp_res.line_number)
                begin
                    $error("line_number: expected %0d, got %0d",
                           exp_res.line_number, got.line_number);
                    error_count++;
                end
                if (got.block_offset !== exp_res.block_offset)
                begin
                    $error("block_offset: expected %0d, got %0d",
                           exp_res.block_offset, got.block_offset);
                    error_count++;
                end
                if (got.last !== exp_res.last)
                begin
                    $error("last: expected %0d, got %0d", exp_res.last, got.last);
                    error_count++;
                end
            end
        end
    end

    task automatic queue_random_words(int count);
        int          pick;
        logic [19:0] blk;
        logic [14:0] seg;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(99);
            // mostly a small working set so hits, evictions and writebacks recur
            blk = (pick < 70) ? 20'($urandom_range(95)) : 20'($urandom);
            seg = (pick < 70) ? 15'($urandom_range(3)) : 15'($urandom);
            pick = $urandom_range(99);
            if (pick < 55)
                pending_words.push_back(pack_word(lwbc_pkg::OP_READ, blk, 15'($urandom)));
            else if (pick < 80)
                pending_words.push_back(pack_word(lwbc_pkg::OP_WRITE, 20'($urandom), seg));
            else if (pick < 93)
                pending_words.push_back(pack_word(lwbc_pkg::OP_FLUSH, blk, seg));
            else
                pending_words.push_back(pack_word(lwbc_pkg::OP_NONE, blk, seg));
        end
    endtask

    task automatic drain_phase();
        while (pending_words.size() > 0 || s_axis_tvalid)
            @(posedge clk);
        while (expected_results.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
        predictor_reset();
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty flush, extremes, all ops, eviction of dirty lines
        pending_words.push_back(pack_word(lwbc_pkg::OP_FLUSH, '0, '0));
        pending_words.push_back(pack_word(lwbc_pkg::OP_READ, 20'hFFFFF, '0));
        pending_words.push_back(pack_word(lwbc_pkg::OP_READ, 20'h00000, 15'h7FFF));
        pending_words.push_back(pack_word(lwbc_pkg::OP_READ, 20'hFFFFE, '0));
        pending_words.push_back(pack_word(lwbc_pkg::OP_NONE, 20'hFFFFF, 15'h7FFF));
        pending_words.push_back(pack_word(lwbc_pkg::OP_WRITE, 20'hFFFFF, 15'h7FFF));
        pending_words.push_back(pack_word(lwbc_pkg::OP_WRITE, '0, 15'h0000));
        pending_words.push_back(pack_word(lwbc_pkg::OP_FLUSH, 20'hFFFFF, 15'h7FFF));
        pending_words.push_back(pack_word(lwbc_pkg::OP_WRITE, '0, 15'h0001));
        pending_words.push_back(pack_word(lwbc_pkg::OP_WRITE, '0, 15'h5555));
        pending_words.push_back(pack_word(lwbc_pkg::OP_READ, 20'h00005, '0));
        pending_words.push_back(pack_word(lwbc_pkg::OP_READ, 20'h00002, '0));
        pending_words.push_back(pack_word(lwbc_pkg::OP_READ, 20'hAAAAA, 15'h2AAA));
        pending_words.push_back(pack_word(lwbc_pkg::OP_READ, 20'h55555, '0));
        pending_words.push_back(pack_word(lwbc_pkg::OP_FLUSH, '0, '0));
        pending_words.push_back(pack_word(lwbc_pkg::OP_WRITE, '0, 15'h2AAA));
        pending_words.push_back(pack_word(lwbc_pkg::OP_FLUSH, '0, '0));
        drain_phase();

        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct = (phase == 1 || phase == 3) ? ((phase == 3) ? 31 : 65) : 0;
            recv_stall_pct = (phase == 2 || phase == 3) ? ((phase == 3) ? 31 : 65) : 0;
            queue_random_words(105);
            drain_phase();
        end
        repeat (40) @(posedge clk);

        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
